[rtl/core/rmcs_pkg.sv]
`default_nettype none
package rmcs_pkg;
   localparam int PIX_W     = 8;
   localparam int RUN_W     = 13;
   localparam int CH_N      = 3;
   localparam int IDX_W     = 3;
   localparam logic [PIX_W-1:0] THR_RESET = 8'd16;
   localparam logic [IDX_W-1:0] IDX_TOP   = 3'd7;

   typedef struct packed {
      logic             accept;
      logic             div_step;
      logic [IDX_W-1:0] div_idx;
      logic             emit2;
   } ctl_cmd_type;

   typedef struct packed {
      logic rsp_free;
      logic emit2_needed;
   } dp_status_type;
endpackage
`default_nettype wire

[rtl/core/running_mean_color_segmenter_unit.sv]
// Output: a segment closed by a color split is offered in the cycle after the request;
// one closed by line end or by reaching MAX_LINE is offered after the accept, the S_DIV
// steps and S_EMIT, which waits for a free output register. Requests are taken only once
// the previous one's accept, 8-step restoring divide of the three channel sums and (at
// line end or MAX_LINE) emit are done, and never while the output register is stalled.
// Reset: split_threshold returns to 16, no segment open, no result pending.
`default_nettype none
module running_mean_color_segmenter_unit import rmcs_pkg::*; #(
   parameter int MAX_LINE = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire logic [PIX_W-1:0] req_pixel_red,
   input  wire logic [PIX_W-1:0] req_pixel_green,
   input  wire logic [PIX_W-1:0] req_pixel_blue,
   input  wire logic             req_line_end,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [PIX_W-1:0]      rsp_seg_red,
   output logic [PIX_W-1:0]      rsp_seg_green,
   output logic [PIX_W-1:0]      rsp_seg_blue,
   output logic [RUN_W-1:0]      rsp_run_length,
   output logic                  rsp_closes_line,
   input  wire logic             csr_wr_en,
   input  wire logic [PIX_W-1:0] csr_wr_data
);
   ctl_cmd_type   cmd;
   dp_status_type status;

   rmcs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   rmcs_dpath #(.MAX_LINE(MAX_LINE)) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_pixel_red   (req_pixel_red),
      .req_pixel_green (req_pixel_green),
      .req_pixel_blue  (req_pixel_blue),
      .req_line_end    (req_line_end),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_seg_red     (rsp_seg_red),
      .rsp_seg_green   (rsp_seg_green),
      .rsp_seg_blue    (rsp_seg_blue),
      .rsp_run_length  (rsp_run_length),
      .rsp_closes_line (rsp_closes_line),
      .cmd             (cmd),
      .status          (status)
   );
endmodule
`default_nettype wire

[rtl/core/rmcs_ctrl.sv]
`default_nettype none
module rmcs_ctrl import rmcs_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   output logic               req_ready,
   input  wire dp_status_type status,
   output ctl_cmd_type        cmd
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_DIV  = 2'd1;
   localparam logic [1:0] S_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;

   assign req_ready = (state_ff == S_IDLE) && status.rsp_free;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      cmd.accept   = 1'b0;
      cmd.div_step = 1'b0;
      cmd.div_idx  = idx_ff;
      cmd.emit2    = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               idx_in     = IDX_TOP;
               state_in   = S_DIV;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            idx_in       = idx_ff - 1'b1;
            if (idx_ff == '0) begin
               state_in = status.emit2_needed ? S_EMIT : S_IDLE;
            end
         end
         S_EMIT: begin
            if (status.rsp_free) begin
               cmd.emit2 = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit2 |-> status.rsp_free) else $error("emit with busy output");
   a_div_len: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |=> (state_ff == S_DIV) && (idx_ff == IDX_TOP))
      else $error("divide did not start");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> !cmd.accept) else $error("accept while busy");
endmodule
`default_nettype wire

[rtl/core/rmcs_dpath.sv]
`default_nettype none
module rmcs_dpath import rmcs_pkg::*; #(
   parameter int MAX_LINE = 4096
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic [PIX_W-1:0] req_pixel_red,
   input  wire logic [PIX_W-1:0] req_pixel_green,
   input  wire logic [PIX_W-1:0] req_pixel_blue,
   input  wire logic             req_line_end,
   input  wire logic             csr_wr_en,
   input  wire logic [PIX_W-1:0] csr_wr_data,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output logic [PIX_W-1:0]      rsp_seg_red,
   output logic [PIX_W-1:0]      rsp_seg_green,
   output logic [PIX_W-1:0]      rsp_seg_blue,
   output logic [RUN_W-1:0]      rsp_run_length,
   output logic                  rsp_closes_line,
   input  wire ctl_cmd_type      cmd,
   output dp_status_type         status
);
   localparam int CNT_W = $clog2(MAX_LINE + 1);
   localparam int SUM_W = CNT_W + PIX_W;

   logic [PIX_W-1:0] thr_ff, thr_in;
   logic [CNT_W-1:0] count_ff, count_in, cnt_new;
   logic [SUM_W-1:0] tot_ff [CH_N];
   logic [SUM_W-1:0] tot_in [CH_N];
   logic [SUM_W-1:0] tot_new [CH_N];
   logic [SUM_W-1:0] rem_ff [CH_N];
   logic [SUM_W-1:0] rem_in [CH_N];
   logic [PIX_W-1:0] mean_ff [CH_N];
   logic [PIX_W-1:0] mean_in [CH_N];
   logic [PIX_W-1:0] pix [CH_N];
   logic [PIX_W-1:0] out_ff [CH_N];
   logic [PIX_W-1:0] out_in [CH_N];
   logic [CH_N-1:0]  over;
   logic [SUM_W-1:0] dsh;
   logic             split, restart;
   logic             last_ff, last_in, full_ff, full_in;
   logic             vld_ff, vld_in, cls_ff, cls_in;
   logic [RUN_W-1:0] run_ff, run_in;

   assign pix[0] = req_pixel_red;
   assign pix[1] = req_pixel_green;
   assign pix[2] = req_pixel_blue;

   assign dsh = SUM_W'(count_ff) << cmd.div_idx;

   always_comb begin
      for (int c = 0; c < CH_N; c++) begin
         over[c] = ((mean_ff[c] > pix[c]) ? (mean_ff[c] - pix[c])
                                          : (pix[c] - mean_ff[c])) > thr_ff;
      end
   end
   assign split   = (count_ff != '0) && (|over);
   assign restart = (count_ff == '0) || split;
   assign cnt_new = restart ? CNT_W'(1) : count_ff + 1'b1;

   always_comb begin
      thr_in   = csr_wr_en ? csr_wr_data : thr_ff;
      count_in = count_ff;
      last_in  = last_ff;
      full_in  = full_ff;
      vld_in   = vld_ff && !rsp_ready;
      cls_in   = cls_ff;
      run_in   = run_ff;
      for (int c = 0; c < CH_N; c++) begin
         tot_new[c] = restart ? SUM_W'(pix[c]) : tot_ff[c] + SUM_W'(pix[c]);
         tot_in[c]  = tot_ff[c];
         rem_in[c]  = rem_ff[c];
         mean_in[c] = mean_ff[c];
         out_in[c]  = out_ff[c];
      end
      if (cmd.accept) begin
         count_in = cnt_new;
         last_in  = req_line_end;
         full_in  = cnt_new >= CNT_W'(MAX_LINE);
         for (int c = 0; c < CH_N; c++) begin
            tot_in[c]  = tot_new[c];
            rem_in[c]  = tot_new[c];
            mean_in[c] = '0;
         end
         if (split) begin
            // closed segment goes out with the mean it was tested against
            vld_in = 1'b1;
            cls_in = 1'b0;
            run_in = RUN_W'(count_ff);
            for (int c = 0; c < CH_N; c++) out_in[c] = mean_ff[c];
         end
      end
      if (cmd.div_step) begin
         for (int c = 0; c < CH_N; c++) begin
            if (rem_ff[c] >= dsh) begin
               rem_in[c]  = rem_ff[c] - dsh;
               mean_in[c] = {mean_ff[c][PIX_W-2:0], 1'b1};
            end else begin
               mean_in[c] = {mean_ff[c][PIX_W-2:0], 1'b0};
            end
         end
      end
      if (cmd.emit2) begin
         vld_in   = 1'b1;
         cls_in   = last_ff;
         run_in   = RUN_W'(count_ff);
         count_in = '0;
         for (int c = 0; c < CH_N; c++) begin
            out_in[c] = mean_ff[c];
            tot_in[c] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff   <= THR_RESET;
         count_ff <= '0;
         vld_ff   <= 1'b0;
         last_ff  <= 1'b0;
         full_ff  <= 1'b0;
      end else begin
         thr_ff   <= thr_in;
         count_ff <= count_in;
         vld_ff   <= vld_in;
         last_ff  <= last_in;
         full_ff  <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      cls_ff <= cls_in;
      run_ff <= run_in;
      for (int c = 0; c < CH_N; c++) begin
         tot_ff[c]  <= tot_in[c];
         rem_ff[c]  <= rem_in[c];
         mean_ff[c] <= mean_in[c];
         out_ff[c]  <= out_in[c];
      end
   end

   assign rsp_valid       = vld_ff;
   assign rsp_seg_red     = out_ff[0];
   assign rsp_seg_green   = out_ff[1];
   assign rsp_seg_blue    = out_ff[2];
   assign rsp_run_length  = run_ff;
   assign rsp_closes_line = cls_ff;

   assign status.rsp_free     = !vld_ff || rsp_ready;
   assign status.emit2_needed = last_ff || full_ff;

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_LINE)) else $error("segment count overflow");
   a_emit_clears: assert property (@(posedge clock) disable iff (reset)
      cmd.emit2 |=> (count_ff == '0) && vld_ff) else $error("emit did not clear");
   a_accept_free: assert property (@(posedge clock) disable iff (reset)
      cmd.accept |-> status.rsp_free) else $error("accept with busy output");
endmodule
`default_nettype wire
